### design/four_component_vector_unit_assert.svh
// assertion helpers for the checker file
`ifndef FOUR_COMPONENT_VECTOR_UNIT_ASSERT_SVH
`define FOUR_COMPONENT_VECTOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FVU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition holds at every edge out of reset
`define FVU_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");

`endif

### design/fvu_pkg.sv
package fvu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LANES      = 4;

  localparam int PROD_W   = 2 * DATA_WIDTH;
  localparam int SUM_W    = PROD_W + 2;
  localparam int ROOT_W   = DATA_WIDTH + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int DVD_W    = DATA_WIDTH + FRAC_BITS;
  localparam int DVS_W    = DATA_WIDTH + 1;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = DVD_W;
  // input register, product, reduce, divisor select, output register
  localparam int LATENCY  = 5 + SQRT_LAT + DIV_LAT;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam word_t SMAX = word_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam word_t SMIN = word_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

  typedef enum logic [3:0] {
    OP_NEG   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_DOT   = 4'd5,
    OP_MAGSQ = 4'd6,
    OP_MAG   = 4'd7,
    OP_NORM  = 4'd8,
    OP_ZTEST = 4'd9
  } op_t;

  typedef struct packed {
    logic ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    logic                          vld;
    op_t                           op;
    logic                          zero;
    word_t [LANES-1:0]             vec;
    logic                          vec_ovf;
    word_t                         rs;
    logic                          rs_ovf;
    logic [LANES-1:0][DVD_W-1:0]   dvd;
    logic [LANES-1:0]              neg;
    logic [DVS_W-1:0]              dvs;
    logic                          dz;
  } side_t;

  // clamp a wide signed value into the word range
  function automatic sat_t sat_wide(input logic signed [SUM_W-1:0] x);
    sat_t s;
    logic fit;
    fit   = (&x[SUM_W-1:DATA_WIDTH-1]) | ~(|x[SUM_W-1:DATA_WIDTH-1]);
    s.ovf = ~fit;
    if (fit) begin
      s.val = x[DATA_WIDTH-1:0];
    end else if (x[SUM_W-1]) begin
      s.val = SMIN;
    end else begin
      s.val = SMAX;
    end
    return s;
  endfunction

endpackage

### design/fvu_sqrt.sv
module fvu_sqrt import fvu_pkg::*; (
  input  logic              clk,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  // one root bit per stage, msb first
  logic [RAD_W-1:0]  rad_r  [SQRT_LAT];
  logic [ROOT_W+1:0] rem_r  [SQRT_LAT];
  logic [ROOT_W-1:0] root_r [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [ROOT_W+1:0] cur;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] rem_nxt;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cur     = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial   = {root_in, 2'b01};
    assign ge      = (cur >= trial);
    assign rem_nxt = ge ? (cur - trial) : cur;

    always_ff @(posedge clk) begin
      rad_r[k]  <= rad_in << 2;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

### design/fvu_div.sv
module fvu_div import fvu_pkg::*; (
  input  logic             clk,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic [DVD_W-1:0] quo
);

  // restoring divide, one quotient bit per stage
  logic [DVD_W-1:0] dvd_r [DIV_LAT];
  logic [DVS_W-1:0] dvs_r [DIV_LAT];
  logic [DVS_W-1:0] rem_r [DIV_LAT];
  logic [DVD_W-1:0] quo_r [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DVD_W-1:0] dvd_in;
    logic [DVS_W-1:0] dvs_in;
    logic [DVS_W-1:0] rem_in;
    logic [DVD_W-1:0] quo_in;
    logic [DVS_W:0]   cur;
    logic [DVS_W:0]   rem_nxt;
    logic             ge;

    if (k == 0) begin : g_first
      assign dvd_in = dvd;
      assign dvs_in = dvs;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign dvd_in = dvd_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign cur     = {rem_in, dvd_in[DVD_W-1]};
    assign ge      = (cur >= {1'b0, dvs_in});
    assign rem_nxt = ge ? (cur - {1'b0, dvs_in}) : cur;

    always_ff @(posedge clk) begin
      dvd_r[k] <= dvd_in << 1;
      dvs_r[k] <= dvs_in;
      rem_r[k] <= rem_nxt[DVS_W-1:0];
      quo_r[k] <= {quo_in[DVD_W-2:0], ge};
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

### design/four_component_vector_unit.sv
// four-component vector unit, signed q16.16 fixed point
//
// input channel: drive in_* with an operation code, vectors a and b and a
// scalar, and raise start for one cycle per transaction. a transaction is
// taken at every rising edge with start high and busy low. busy is high only
// while rst_n is low, so one transaction can enter in every cycle.
// result channel: every transaction gives exactly one result. out_strobe is
// high for one cycle with out_r_*, out_r_scalar and the three flags valid;
// the receiver takes it at the edge that ends that cycle and cannot hold it
// off, so nothing in the pipe ever waits.
// every operation takes the same path, so the result delay is the same whatever
// the operation. throughput: one per cycle.
// the pipe holds the 33-stage square root (one root bit per stage)
// followed by the 48-stage divider lanes (one quotient bit per stage).
// reset: synchronous, clears every valid bit, so transactions in flight are
// dropped and no strobe follows until new ones enter.
module four_component_vector_unit import fvu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       start,
  output logic       busy,
  input  logic [3:0] in_operation,
  input  word_t      in_a_x,
  input  word_t      in_a_y,
  input  word_t      in_a_z,
  input  word_t      in_a_w,
  input  word_t      in_b_x,
  input  word_t      in_b_y,
  input  word_t      in_b_z,
  input  word_t      in_b_w,
  input  word_t      in_scalar_in,
  // result channel
  output logic       out_strobe,
  output word_t      out_r_x,
  output word_t      out_r_y,
  output word_t      out_r_z,
  output word_t      out_r_w,
  output word_t      out_r_scalar,
  output logic       out_zero_flag,
  output logic       out_overflow_flag,
  output logic       out_div_zero_flag
);

  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------
  logic              s0_vld_r;
  op_t               s0_op_r;
  word_t [LANES-1:0] s0_a_r;
  word_t [LANES-1:0] s0_b_r;
  word_t             s0_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_op_r <= op_t'(in_operation);
    s0_a_r  <= {in_a_w, in_a_z, in_a_y, in_a_x};
    s0_b_r  <= {in_b_w, in_b_z, in_b_y, in_b_x};
    s0_sc_r <= in_scalar_in;
  end

  // ---------------------------------------------------------------------
  // stage 1: one multiplier per lane, plus the add/sub/negate results
  // ---------------------------------------------------------------------
  word_t                    mul_b     [LANES];
  logic signed [SUM_W-1:0]  s1_wide   [LANES];
  sat_t                     s1_sat    [LANES];
  logic signed [PROD_W-1:0] prod_nxt  [LANES];

  logic                     s1_vld_r;
  op_t                      s1_op_r;
  logic                     s1_zero_r;
  logic signed [PROD_W-1:0] s1_prod_r [LANES];
  word_t [LANES-1:0]        s1_simp_r;
  logic [LANES-1:0]         s1_simp_ovf_r;
  word_t [LANES-1:0]        s1_a_r;
  word_t                    s1_sc_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      case (s0_op_r)
        OP_SCALE: mul_b[i] = s0_sc_r;
        OP_DOT:   mul_b[i] = s0_b_r[i];
        default:  mul_b[i] = s0_a_r[i];
      endcase
      prod_nxt[i] = $signed(PROD_W'(s0_a_r[i])) * $signed(PROD_W'(mul_b[i]));

      case (s0_op_r)
        OP_ADD:  s1_wide[i] = $signed(SUM_W'(s0_a_r[i])) + $signed(SUM_W'(s0_b_r[i]));
        OP_SUB:  s1_wide[i] = $signed(SUM_W'(s0_a_r[i])) - $signed(SUM_W'(s0_b_r[i]));
        default: s1_wide[i] = -$signed(SUM_W'(s0_a_r[i]));
      endcase
      s1_sat[i] = sat_wide(s1_wide[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r   <= s0_op_r;
    s1_zero_r <= (s0_a_r == '0);
    s1_a_r    <= s0_a_r;
    s1_sc_r   <= s0_sc_r;
    for (int i = 0; i < LANES; i++) begin
      s1_prod_r[i]     <= prod_nxt[i];
      s1_simp_r[i]     <= s1_sat[i].val;
      s1_simp_ovf_r[i] <= s1_sat[i].ovf;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: floor the products, reduce, build the divide operands
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] fl      [LANES];
  sat_t                    sc_sat  [LANES];
  logic signed [SUM_W-1:0] dot_sum;
  sat_t                    dot_sat;
  logic [RAD_W-1:0]        rad_sum;
  logic [DATA_WIDTH-1:0]   a_mag   [LANES];
  logic [DATA_WIDTH-1:0]   sc_mag;
  logic [LANES-1:0]        sc_ovf;
  side_t                   s2_nxt;

  side_t                   s2_side_r;
  logic [RAD_W-1:0]        s2_rad_r;

  always_comb begin
    dot_sum = '0;
    rad_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      // arithmetic shift is the floor of the scaled product
      fl[i]     = SUM_W'(s1_prod_r[i] >>> FRAC_BITS);
      sc_sat[i] = sat_wide(fl[i]);
      sc_ovf[i] = sc_sat[i].ovf;
      dot_sum   = dot_sum + fl[i];
      rad_sum   = rad_sum + RAD_W'($unsigned(s1_prod_r[i]));
      a_mag[i]  = s1_a_r[i][DATA_WIDTH-1] ? DATA_WIDTH'(-s1_a_r[i])
                                          : DATA_WIDTH'(s1_a_r[i]);
    end
    dot_sat = sat_wide(dot_sum);
    sc_mag  = s1_sc_r[DATA_WIDTH-1] ? DATA_WIDTH'(-s1_sc_r) : DATA_WIDTH'(s1_sc_r);

    s2_nxt      = '0;
    s2_nxt.vld  = s1_vld_r;
    s2_nxt.op   = s1_op_r;
    s2_nxt.zero = s1_zero_r;
    case (s1_op_r)
      OP_NEG, OP_ADD, OP_SUB: begin
        s2_nxt.vec     = s1_simp_r;
        s2_nxt.vec_ovf = |s1_simp_ovf_r;
      end
      OP_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          s2_nxt.vec[i] = sc_sat[i].val;
        end
        s2_nxt.vec_ovf = |sc_ovf;
      end
      OP_DOT, OP_MAGSQ: begin
        s2_nxt.rs     = dot_sat.val;
        s2_nxt.rs_ovf = dot_sat.ovf;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < LANES; i++) begin
      s2_nxt.dvd[i] = {a_mag[i], {FRAC_BITS{1'b0}}};
      s2_nxt.neg[i] = s1_a_r[i][DATA_WIDTH-1] ^
                      ((s1_op_r == OP_DIV) & s1_sc_r[DATA_WIDTH-1]);
    end
    s2_nxt.dvs = {1'b0, sc_mag};
    s2_nxt.dz  = (s1_op_r == OP_DIV) && (s1_sc_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.vld <= 1'b0;
    end else begin
      s2_side_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_rad_r <= rad_sum;
  end

  // ---------------------------------------------------------------------
  // square root of the sum of squares, side data delayed alongside
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side_r [SQRT_LAT];

  fvu_sqrt u_sqrt (
    .clk  (clk),
    .rad  (s2_rad_r),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        sq_side_r[k].vld <= 1'b0;
      end
    end else begin
      sq_side_r[0] <= s2_side_r;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // divisor select: magnitude result and normalize divisor from the root
  // ---------------------------------------------------------------------
  side_t sd_nxt;
  side_t sd_side_r;

  always_comb begin
    sd_nxt = sq_side_r[SQRT_LAT-1];
    case (sd_nxt.op)
      OP_MAG: begin
        sd_nxt.rs_ovf = |sq_root[ROOT_W-1:DATA_WIDTH-1];
        sd_nxt.rs     = sd_nxt.rs_ovf ? SMAX : word_t'(sq_root[DATA_WIDTH-1:0]);
      end
      OP_NORM: begin
        sd_nxt.dvs = sq_root;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_side_r.vld <= 1'b0;
    end else begin
      sd_side_r <= sd_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // divider lanes, side data delayed alongside
  // ---------------------------------------------------------------------
  logic [DVD_W-1:0] quo       [LANES];
  side_t            dv_side_r [DIV_LAT];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fvu_div u_div (
      .clk (clk),
      .dvd (sd_side_r.dvd[i]),
      .dvs (sd_side_r.dvs),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dv_side_r[k].vld <= 1'b0;
      end
    end else begin
      dv_side_r[0] <= sd_side_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // sign, saturate and pick the quotients, then the output register
  // ---------------------------------------------------------------------
  side_t            fin;
  word_t            lane_val [LANES];
  logic [LANES-1:0] lane_ovf;
  logic             use_div;

  always_comb begin
    fin = dv_side_r[DIV_LAT-1];
    for (int i = 0; i < LANES; i++) begin
      if (fin.neg[i]) begin
        // magnitude may reach exactly two to the word width minus one
        lane_ovf[i] = (|quo[i][DVD_W-1:DATA_WIDTH]) |
                      (quo[i][DATA_WIDTH-1] & (|quo[i][DATA_WIDTH-2:0]));
        lane_val[i] = lane_ovf[i] ? SMIN : word_t'(-quo[i][DATA_WIDTH-1:0]);
      end else begin
        lane_ovf[i] = |quo[i][DVD_W-1:DATA_WIDTH-1];
        lane_val[i] = lane_ovf[i] ? SMAX : word_t'(quo[i][DATA_WIDTH-1:0]);
      end
    end
    use_div = ((fin.op == OP_DIV) && !fin.dz) || ((fin.op == OP_NORM) && !fin.zero);
    if (use_div) begin
      for (int i = 0; i < LANES; i++) begin
        fin.vec[i] = lane_val[i];
      end
      fin.vec_ovf = |lane_ovf;
    end
  end

  logic  out_strobe_r;
  word_t out_x_r;
  word_t out_y_r;
  word_t out_z_r;
  word_t out_w_r;
  word_t out_scalar_r;
  logic  out_zero_r;
  logic  out_ovf_r;
  logic  out_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.vld) begin
      out_x_r      <= fin.vec[0];
      out_y_r      <= fin.vec[1];
      out_z_r      <= fin.vec[2];
      out_w_r      <= fin.vec[3];
      out_scalar_r <= fin.rs;
      out_zero_r   <= fin.zero;
      out_ovf_r    <= fin.vec_ovf | fin.rs_ovf;
      out_dz_r     <= fin.dz;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_r_x           = out_x_r;
  assign out_r_y           = out_y_r;
  assign out_r_z           = out_z_r;
  assign out_r_w           = out_w_r;
  assign out_r_scalar      = out_scalar_r;
  assign out_zero_flag     = out_zero_r;
  assign out_overflow_flag = out_ovf_r;
  assign out_div_zero_flag = out_dz_r;

endmodule

### design/fvu_checker.sv
`include "four_component_vector_unit_assert.svh"

module fvu_checker import fvu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [3:0] in_operation,
  input word_t      in_a_x,
  input word_t      in_a_y,
  input word_t      in_a_z,
  input word_t      in_a_w,
  input word_t      in_b_x,
  input word_t      in_b_y,
  input word_t      in_b_z,
  input word_t      in_b_w,
  input word_t      in_scalar_in,
  input logic       out_strobe,
  input word_t      out_r_x,
  input word_t      out_r_y,
  input word_t      out_r_z,
  input word_t      out_r_w,
  input word_t      out_r_scalar,
  input logic       out_zero_flag,
  input logic       out_overflow_flag,
  input logic       out_div_zero_flag
);

  logic acc_in;
  logic a_zero;
  logic dz_cause;
  logic r_zero;

  assign acc_in   = start && !busy;
  assign a_zero   = ({in_a_w, in_a_z, in_a_y, in_a_x} == '0);
  assign dz_cause = (in_operation == OP_DIV) && (in_scalar_in == '0);
  assign r_zero   = ({out_r_w, out_r_z, out_r_y, out_r_x, out_r_scalar} == '0);

  // every result traces back to an accepted transaction
  `FVU_ASSERT_IMP(a_strobe_has_cause, out_strobe, $past(acc_in, LATENCY))

  // zero flag matches the first vector of that transaction
  `FVU_ASSERT_IMP(a_zero_flag_src, out_strobe, out_zero_flag == $past(a_zero, LATENCY))

  // divide by zero only for a divide with a zero scalar
  `FVU_ASSERT_IMP(a_div_zero_src, out_strobe && out_div_zero_flag, $past(dz_cause, LATENCY))

  // divide by zero gives an all zero result and no overflow
  `FVU_ASSERT_IMP(a_div_zero_res, out_strobe && out_div_zero_flag, r_zero && !out_overflow_flag)

endmodule

bind four_component_vector_unit fvu_checker u_fvu_checker (.*);
